// ===== design/task_queue_registry_core_macros.svh =====
// ----------------------------------------------------------------------------
// task queue registry assertion macros
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TASK_QUEUE_REGISTRY_CORE_MACROS_SVH
`define TASK_QUEUE_REGISTRY_CORE_MACROS_SVH

`ifndef SYNTH
// ante implies cons in the same cycle
`define TQR_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tqr assertion failed");
// ante implies cons in the following cycle
`define TQR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tqr assertion failed");
`else
`define TQR_ASSERT(lbl, clk, rstn, ante, cons)
`define TQR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/tqr_pkg.sv =====
// ----------------------------------------------------------------------------
// task queue registry package
// default sizes and the action, mode and status codes
// ----------------------------------------------------------------------------
`default_nettype none

package tqr_pkg;

    localparam int MAX_TASKS_DEF        = 64;
    localparam int HANDLES_PER_TASK_DEF = 16;
    localparam int HANDLE_BITS_DEF      = 32;

    typedef enum logic [1:0] {
        ACT_REGISTER   = 2'd0,
        ACT_UNREGISTER = 2'd1,
        ACT_LOOKUP     = 2'd2,
        ACT_CLEANUP    = 2'd3
    } t_action;

    localparam logic [1:0] MODE_INVALID = 2'd3;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NULL       = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_DUPLICATE  = 3'd3,
        ST_LIST_FULL  = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } t_status;

endpackage

`default_nettype wire

// ===== design/tqr_ram.sv =====
// ----------------------------------------------------------------------------
// tqr generic ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module tqr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/task_queue_registry_core.sv =====
// ----------------------------------------------------------------------------
// task queue registry core
// table of task ids, each with an ordered list of nonzero queue handles
// ----------------------------------------------------------------------------
// One item is handled at a time. The task table is searched from slot 0,
// each slot in two steps (read the id memory, then compare). Register and
// unregister then read the handle count and compare the handles one by one;
// unregister shifts the later handles down, one read and one write each.
// Cleanup compacts the table by copying every later slot down, its id and
// count and then each handle it holds. A result then waits in the done state
// until the output register is empty or being emptied. Each memory has a
// single read port with registered read data, so every read is issued in one
// state and used in the next. A new item is taken as soon as the previous one
// has reached the output register, even while that result waits. There is
// no clearing pass after reset: only entries that were written are read.
`default_nettype none

`include "task_queue_registry_core_macros.svh"

module task_queue_registry_core #(
    parameter int MAX_TASKS        = tqr_pkg::MAX_TASKS_DEF,
    parameter int HANDLES_PER_TASK = tqr_pkg::HANDLES_PER_TASK_DEF,
    parameter int HANDLE_BITS      = tqr_pkg::HANDLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_task_id,
    input  wire logic [31:0] i_queue_handle,
    input  wire logic [1:0]  i_find_mode,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_out_found_handle,
    output logic [2:0]       o_out_status
);

    import tqr_pkg::*;

    localparam int SW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int UW  = $clog2(MAX_TASKS + 1);
    localparam int CW  = $clog2(HANDLES_PER_TASK + 1);
    localparam int KW  = (HANDLES_PER_TASK > 1) ? $clog2(HANDLES_PER_TASK) : 1;
    localparam int HD  = MAX_TASKS * HANDLES_PER_TASK;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int HW  = HANDLE_BITS;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_TRD  = 16'h0002, // issue task id read
        S_TCMP = 16'h0004, // compare task id
        S_CRD  = 16'h0008, // issue count read
        S_CGET = 16'h0010, // count available
        S_HRD  = 16'h0020, // issue handle read for scan
        S_HCMP = 16'h0040, // compare handle
        S_SHRD = 16'h0080, // shift: read next handle
        S_SHWR = 16'h0100, // shift: write it one place down
        S_LKW  = 16'h0200, // lookup: first handle available
        S_APP  = 16'h0400, // append handle (and create entry)
        S_CPRD = 16'h0800, // compaction: read next slot id and count
        S_CPWR = 16'h1000, // compaction: write id and count down
        S_CHRD = 16'h2000, // compaction: read handle of next slot
        S_CHWR = 16'h4000, // compaction: write handle down
        S_DONE = 16'h8000  // result ready for the output register
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [UW-1:0]   r_used, n_used;
    logic            r_out_valid, n_out_valid;

    // working payload
    t_action         r_action, n_action;
    logic [31:0]     r_id, n_id;
    logic [HW-1:0]   r_h, n_h;
    logic [1:0]      r_mode, n_mode;
    logic [SW-1:0]   r_idx, n_idx;
    logic [KW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_new, n_new;
    t_status         r_status, n_status;
    logic [HW-1:0]   r_found, n_found;
    t_status         r_out_status, n_out_status;
    logic [31:0]     r_out_found, n_out_found;

    // memory ports
    logic            tid_we, cnt_we, hdl_we;
    logic [SW-1:0]   tid_waddr, tid_raddr;
    logic [31:0]     tid_wdata, tid_q;
    logic [CW-1:0]   cnt_wdata, cnt_q;
    logic [HAW-1:0]  hdl_waddr, hdl_raddr;
    logic [HW-1:0]   hdl_wdata, hdl_q;

    logic            in_acc;
    logic [HW-1:0]   h_in;
    logic [UW-1:0]   idx_p1_u, idx_p2_u;
    logic [CW-1:0]   k_p1_c;
    logic            last_slot, last_k;
    logic [HAW-1:0]  hbase_idx, hbase_nxt;

    tqr_ram #(.WIDTH(32), .DEPTH(MAX_TASKS), .AW(SW)) u_tid_ram (
        .i_clk   (i_clk),
        .i_we    (tid_we),
        .i_waddr (tid_waddr),
        .i_wdata (tid_wdata),
        .i_raddr (tid_raddr),
        .o_rdata (tid_q)
    );

    // count memory shares its addresses with the id memory
    tqr_ram #(.WIDTH(CW), .DEPTH(MAX_TASKS), .AW(SW)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (tid_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (tid_raddr),
        .o_rdata (cnt_q)
    );

    // handle lists, one row of HANDLES_PER_TASK entries per slot
    tqr_ram #(.WIDTH(HW), .DEPTH(HD), .AW(HAW)) u_hdl_ram (
        .i_clk   (i_clk),
        .i_we    (hdl_we),
        .i_waddr (hdl_waddr),
        .i_wdata (hdl_wdata),
        .i_raddr (hdl_raddr),
        .o_rdata (hdl_q)
    );

    assign o_in_stall         = (r_state != S_IDLE);
    assign in_acc             = i_in_valid && !o_in_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_found_handle = r_out_found;
    assign o_out_status       = r_out_status;

    // handle masked or widened to the stored width
    assign h_in      = HW'(i_queue_handle);
    assign idx_p1_u  = UW'(r_idx) + UW'(1);
    assign idx_p2_u  = UW'(r_idx) + UW'(2);
    assign k_p1_c    = CW'(r_k) + CW'(1);
    assign last_slot = (idx_p1_u == r_used);
    assign last_k    = (k_p1_c == r_cnt);
    assign hbase_idx = HAW'(r_idx) * HAW'(HANDLES_PER_TASK);
    assign hbase_nxt = hbase_idx + HAW'(HANDLES_PER_TASK);

    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_out_valid  = r_out_valid;
        n_action     = r_action;
        n_id         = r_id;
        n_h          = r_h;
        n_mode       = r_mode;
        n_idx        = r_idx;
        n_k          = r_k;
        n_cnt        = r_cnt;
        n_new        = r_new;
        n_status     = r_status;
        n_found      = r_found;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;

        tid_we    = 1'b0;
        cnt_we    = 1'b0;
        hdl_we    = 1'b0;
        tid_waddr = r_idx;
        tid_wdata = tid_q;
        cnt_wdata = cnt_q;
        tid_raddr = r_idx;
        hdl_waddr = hbase_idx + HAW'(r_k);
        hdl_wdata = hdl_q;
        hdl_raddr = hbase_idx + HAW'(r_k);

        // output register empties when its item is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_action = t_action'(i_action);
                    n_id     = i_task_id;
                    n_h      = h_in;
                    n_mode   = i_find_mode;
                    n_idx    = '0;
                    n_k      = '0;
                    n_cnt    = '0;
                    n_new    = 1'b0;
                    n_found  = '0;
                    priority if ((t_action'(i_action) == ACT_REGISTER
                                  || t_action'(i_action) == ACT_UNREGISTER)
                                 && h_in == '0) begin
                        n_status = ST_NULL;
                        n_state  = S_DONE;
                    end else if (r_used == '0) begin
                        // empty table: only register can succeed
                        if (t_action'(i_action) == ACT_REGISTER) begin
                            n_new   = 1'b1;
                            n_state = S_APP;
                        end else begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_state = S_TRD;
                    end
                end
            end
            S_TRD: begin
                n_state = S_TCMP;
            end
            S_TCMP: begin
                priority if (tid_q == r_id) begin
                    if (r_action == ACT_CLEANUP) begin
                        if (last_slot) begin
                            n_used   = r_used - UW'(1);
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_CPRD;
                        end
                    end else begin
                        n_state = S_CRD;
                    end
                end else if (last_slot) begin
                    // task absent
                    if (r_action == ACT_REGISTER) begin
                        if (r_used == UW'(MAX_TASKS)) begin
                            n_status = ST_TABLE_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_idx   = SW'(r_used);
                            n_cnt   = '0;
                            n_new   = 1'b1;
                            n_state = S_APP;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_idx   = SW'(idx_p1_u);
                    n_state = S_TRD;
                end
            end
            S_CRD: begin
                n_state = S_CGET;
            end
            S_CGET: begin
                // first handle read is issued here with r_k at zero
                n_cnt = cnt_q;
                unique case (r_action)
                    ACT_LOOKUP: begin
                        if (r_mode == MODE_INVALID || cnt_q == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_LKW;
                        end
                    end
                    ACT_REGISTER: begin
                        n_state = (cnt_q == '0) ? S_APP : S_HRD;
                    end
                    ACT_UNREGISTER: begin
                        if (cnt_q == '0) begin
                            n_status = ST_NOT_FOUND;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_HRD;
                        end
                    end
                    default: begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_HRD: begin
                n_state = S_HCMP;
            end
            S_HCMP: begin
                priority if (hdl_q == r_h) begin
                    if (r_action == ACT_REGISTER) begin
                        n_status = ST_DUPLICATE;
                        n_state  = S_DONE;
                    end else if (last_k) begin
                        cnt_we    = 1'b1;
                        cnt_wdata = r_cnt - CW'(1);
                        n_status  = ST_OK;
                        n_state   = S_DONE;
                    end else begin
                        n_k     = KW'(k_p1_c);
                        n_state = S_SHRD;
                    end
                end else if (last_k) begin
                    if (r_action == ACT_REGISTER) begin
                        if (r_cnt == CW'(HANDLES_PER_TASK)) begin
                            n_status = ST_LIST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_APP;
                        end
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_k     = KW'(k_p1_c);
                    n_state = S_HRD;
                end
            end
            S_SHRD: begin
                n_state = S_SHWR;
            end
            S_SHWR: begin
                hdl_we    = 1'b1;
                hdl_waddr = hbase_idx + HAW'(r_k) - HAW'(1);
                hdl_wdata = hdl_q;
                if (last_k) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = r_cnt - CW'(1);
                    n_status  = ST_OK;
                    n_state   = S_DONE;
                end else begin
                    n_k     = KW'(k_p1_c);
                    n_state = S_SHRD;
                end
            end
            S_LKW: begin
                n_found  = hdl_q;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_APP: begin
                hdl_we    = 1'b1;
                hdl_waddr = hbase_idx + HAW'(r_cnt);
                hdl_wdata = r_h;
                cnt_we    = 1'b1;
                cnt_wdata = r_cnt + CW'(1);
                if (r_new) begin
                    tid_we    = 1'b1;
                    tid_wdata = r_id;
                    n_used    = r_used + UW'(1);
                end
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_CPRD: begin
                tid_raddr = SW'(idx_p1_u);
                n_state   = S_CPWR;
            end
            S_CPWR: begin
                tid_we    = 1'b1;
                tid_wdata = tid_q;
                cnt_we    = 1'b1;
                cnt_wdata = cnt_q;
                n_cnt     = cnt_q;
                n_k       = '0;
                if (cnt_q != '0) begin
                    n_state = S_CHRD;
                end else if (idx_p2_u == r_used) begin
                    n_used   = r_used - UW'(1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = SW'(idx_p1_u);
                    n_state = S_CPRD;
                end
            end
            S_CHRD: begin
                hdl_raddr = hbase_nxt + HAW'(r_k);
                n_state   = S_CHWR;
            end
            S_CHWR: begin
                hdl_we    = 1'b1;
                hdl_wdata = hdl_q;
                if (!last_k) begin
                    n_k     = KW'(k_p1_c);
                    n_state = S_CHRD;
                end else if (idx_p2_u == r_used) begin
                    n_used   = r_used - UW'(1);
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = SW'(idx_p1_u);
                    n_state = S_CPRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = 32'(r_found);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_id         <= n_id;
        r_h          <= n_h;
        r_mode       <= n_mode;
        r_idx        <= n_idx;
        r_k          <= n_k;
        r_cnt        <= n_cnt;
        r_new        <= n_new;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
    end

    // table never holds more tasks than it has slots
    `TQR_ASSERT(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= UW'(MAX_TASKS))
    // task count moves only while an item is being worked on
    `TQR_ASSERT_NEXT(a_used_quiet, i_clk, i_rst_n, r_state == S_IDLE && !in_acc, r_used == $past(r_used))
    // a nonzero handle is only ever returned with an ok status
    `TQR_ASSERT(a_found_ok, i_clk, i_rst_n, o_out_valid && o_out_found_handle != '0, o_out_status == ST_OK)
    // status codes stay within the defined set
    `TQR_ASSERT(a_status_range, i_clk, i_rst_n, o_out_valid, o_out_status <= ST_NOT_FOUND)

endmodule

`default_nettype wire
